@@ src/bvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap video scan-out package
// Shared constants, codes and structs of the 1bpp bitmap video scan-out.
// ----------------------------------------------------------------------------
package bvs_pkg;

	localparam int unsigned RAM_BYTES     = 8192;
	localparam int unsigned RAM_AW        = 13;
	localparam int unsigned DEF_FIRST_ROW = 32;

	localparam logic [8:0] LAST_COL      = 9'd259;
	localparam logic [2:0] LOAD_PHASE    = 3'd4;
	localparam logic [7:0] LAST_RAW_ROW  = 8'd255;
	localparam logic [7:0] FLIP_ROW_BASE = 8'd223;
	localparam logic [8:0] FLIP_COL_BASE = 9'd261;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_TICK  = 1'b1
	} func_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	typedef struct packed {
		logic       pixel_on;
		logic [7:0] row;
		logic [8:0] column;
		logic       frame_end;
	} pix_t;

endpackage

@@ src/bvs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Writes and reads share one address; read data is registered.
// ----------------------------------------------------------------------------
module bvs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/bvs_scan.sv @@
// ----------------------------------------------------------------------------
// Scan-out sequencer
// Beam counters, pixel shifter and video RAM access for writes and fetches.
// ----------------------------------------------------------------------------
module bvs_scan
	import bvs_pkg::*;
#(
	parameter int unsigned FIRST_ROW = DEF_FIRST_ROW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              func,
	input  logic [RAM_AW-1:0] write_address,
	input  logic [7:0]        write_data,
	input  logic              flip,
	input  logic [7:0]        rdata,
	output ram_req_t          ram_req,
	output logic              res_valid,
	output pix_t              res
);

	localparam logic [7:0] FIRST_ROW_B = 8'(FIRST_ROW);

	logic [8:0] col_q;
	logic [7:0] raw_row_q;
	logic [7:0] shifter_q;
	logic       fetched_q;

	logic [7:0] shifter_eff;
	logic [8:0] col_next;
	logic       line_end;
	logic       frame_last;
	logic       load;
	logic       tick;
	logic [7:0] row_rel;

	// A fetched byte sits in the RAM read register until the next tick
	// consumes it. Reads and writes never share a cycle, and the byte is
	// captured when fetched, so later writes to that entry cannot disturb it.
	assign shifter_eff = fetched_q ? rdata : shifter_q;
	assign tick        = accept && (func_t'(func) == FUNC_TICK);
	assign col_next    = col_q + 9'd1;
	assign line_end    = col_q >= LAST_COL;
	assign frame_last  = line_end && (raw_row_q == LAST_RAW_ROW);
	assign load        = !line_end && !col_next[8] && (col_next[2:0] == LOAD_PHASE);
	assign row_rel     = raw_row_q - FIRST_ROW_B;

	always_comb begin
		ram_req.we    = accept && (func_t'(func) == FUNC_WRITE);
		ram_req.re    = tick && load;
		ram_req.addr  = ram_req.we ? write_address : {raw_row_q, col_next[7:3]};
		ram_req.wdata = write_data;
	end

	always_comb begin
		res_valid     = tick;
		res.pixel_on  = shifter_eff[0];
		res.row       = flip ? (FLIP_ROW_BASE - row_rel) : row_rel;
		res.column    = flip ? (FLIP_COL_BASE - col_q) : col_q;
		res.frame_end = frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			raw_row_q <= FIRST_ROW_B;
			shifter_q <= '0;
			fetched_q <= 1'b0;
		end else if (tick) begin
			if (line_end) begin
				col_q     <= '0;
				raw_row_q <= frame_last ? FIRST_ROW_B : raw_row_q + 8'd1;
				shifter_q <= frame_last ? 8'd0 : (shifter_eff >> 1);
				fetched_q <= 1'b0;
			end else begin
				col_q     <= col_next;
				shifter_q <= shifter_eff >> 1;
				fetched_q <= load;
			end
		end
	end

endmodule

@@ src/bvs_outq.sv @@
// ----------------------------------------------------------------------------
// Result output queue
// Output register with one skid entry between the sequencer and the sink.
// ----------------------------------------------------------------------------
module bvs_outq
	import bvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t push_data,
	input  logic out_stall,
	output logic out_valid,
	output pix_t out_data,
	output logic full
);

	logic out_valid_q;
	logic skid_valid_q;
	pix_t out_q;
	pix_t skid_q;
	logic pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (out_valid_q) begin
			skid_valid_q <= skid_valid_q || push;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (out_valid_q) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else begin
			out_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

endmodule

@@ src/bitmap_video_scanout_1bpp_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap video scan-out, one bit per pixel
// Video RAM written by CPU requests; pixel ticks scan it out one pixel each.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid / in_stall     func, write_address, write_data
//   out      source     out_valid / out_stall   pixel_on, row, column, frame_end
//   cfg      sink       cfg_write_en            cfg_write_data (flip)
//
// One request is taken every cycle while in_stall is low; a tick's result
// goes to the output register or its skid entry. The byte fetch of a tick
// reads the single video RAM port and is used by the following tick.
// Reset clears the counters and the shifter; video RAM is not cleared.
// in_stall rises only when both the output register and its skid entry hold
// results that the sink has not taken.
// ----------------------------------------------------------------------------
module bitmap_video_scanout_1bpp_unit
	import bvs_pkg::*;
#(
	parameter int unsigned FIRST_ROW = DEF_FIRST_ROW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [RAM_AW-1:0] write_address,
	input  logic [7:0]        write_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pixel_on,
	output logic [7:0]        row,
	output logic [8:0]        column,
	output logic              frame_end
);

	logic     flip_q;
	logic     accept;
	logic     full;
	logic     res_valid;
	logic     [7:0] rdata;
	ram_req_t ram_req;
	pix_t     res;
	pix_t     out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (cfg_write_en) begin
			flip_q <= cfg_write_data;
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	bvs_scan #(
		.FIRST_ROW(FIRST_ROW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.write_address(write_address),
		.write_data   (write_data),
		.flip         (flip_q),
		.rdata        (rdata),
		.ram_req      (ram_req),
		.res_valid    (res_valid),
		.res          (res)
	);

	bvs_ram #(
		.WIDTH(8),
		.DEPTH(RAM_BYTES)
	) u_vram (
		.clk  (clk),
		.we   (ram_req.we),
		.re   (ram_req.re),
		.addr (ram_req.addr),
		.wdata(ram_req.wdata),
		.rdata(rdata)
	);

	bvs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.full     (full)
	);

	assign pixel_on  = out_data.pixel_on;
	assign row       = out_data.row;
	assign column    = out_data.column;
	assign frame_end = out_data.frame_end;

endmodule

@@ src/bvs_checker.sv @@
// ----------------------------------------------------------------------------
// Scan-out port checker
// Port-level properties of the scan-out unit, bound to the top level.
// ----------------------------------------------------------------------------
module bvs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       func,
	input logic       out_valid,
	input logic       out_stall,
	input logic       pixel_on,
	input logic [7:0] row,
	input logic [8:0] column,
	input logic       frame_end
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_on) && $stable(row)
			&& $stable(column) && $stable(frame_end))
		else $error("stalled result changed");

	// The frame end falls on the last column of a line, mirrored or not.
	a_frame_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> column == 9'd259 || column == 9'd2)
		else $error("frame end off the last column");

	// Input is held back only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// A result only appears after a pixel tick request was taken.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && func))
		else $error("result without a tick request");

endmodule

bind bitmap_video_scanout_1bpp_unit bvs_checker u_bvs_checker (.*);
